/* sv/csd_pkg.sv */
// Package for the clock set and display control block: types, codes and helper functions.
`default_nettype none

package csd_pkg;

   // Widths of the stream words.
   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 48;
   localparam int unsigned RELOAD_W   = 16;

   // Reset value of the settle reload register.
   localparam logic [RELOAD_W-1:0] SETTLE_RELOAD_RESET = 16'd250;

   // Switch bit positions in the port expander byte.
   localparam int unsigned HOUR_SW_BIT   = 4;
   localparam int unsigned MINUTE_SW_BIT = 5;

   // Highest legal hour and minute before wrapping.
   localparam logic [5:0] HOUR_MAX   = 6'd12;
   localparam logic [7:0] MINUTE_MAX = 8'd59;

   // Segment codes that are not digits.
   localparam logic [7:0] SEG_BLANK    = 8'hFF;
   localparam logic [7:0] SEG_DOT_MASK = 8'h7F;

   // Held state of one pass.
   typedef struct packed {
      logic [6:0]          seconds_value;
      logic [6:0]          minutes_value;
      logic [4:0]          hours_value;
      logic [6:0]          last_seconds_seen;
      logic                dot_lit;
      logic                hour_switch_last;
      logic                minute_switch_last;
      logic                write_pending;
      logic [RELOAD_W-1:0] settle_count;
   } csd_state_type;

   // Fields of one input word.
   typedef struct packed {
      logic [7:0] switch_byte;
      logic [7:0] rtc_hours_raw;
      logic [7:0] rtc_minutes_raw;
      logic [7:0] rtc_seconds_raw;
   } csd_req_type;

   // Fields of one result word.
   typedef struct packed {
      logic [7:0] write_hours_bcd;
      logic [7:0] write_minutes_bcd;
      logic       write_request;
      logic       clock_read_taken;
      logic [7:0] hour_segments;
      logic [7:0] min_tens_segments;
      logic [7:0] min_ones_segments;
   } csd_rsp_type;

   // Active-low seven-segment code for a decimal digit.
   function automatic logic [7:0] digit_code(input logic [3:0] d);
      logic [7:0] c;
      case (d)
         4'd0:    c = 8'hC0;
         4'd1:    c = 8'hF9;
         4'd2:    c = 8'hA4;
         4'd3:    c = 8'hB0;
         4'd4:    c = 8'h99;
         4'd5:    c = 8'h92;
         4'd6:    c = 8'h82;
         4'd7:    c = 8'hF8;
         4'd8:    c = 8'h80;
         4'd9:    c = 8'h90;
         default: c = SEG_BLANK;
      endcase
      return c;
   endfunction

   // Hour symbol: digits, then A for ten, b for eleven and 0 for twelve.
   function automatic logic [7:0] hour_code(input logic [3:0] h);
      logic [7:0] c;
      case (h)
         4'd10:   c = 8'h88;
         4'd11:   c = 8'h83;
         4'd12:   c = 8'hC0;
         default: c = digit_code(h);
      endcase
      return c;
   endfunction

   // Binary to BCD for values below 100: tens by reciprocal multiply, ones by remainder.
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  q;
      logic [6:0]  r;
      prod = 15'(v) * 15'd205;
      q    = prod[14:11];
      r    = v - 7'(7'(q) * 7'd10);
      return {q, r[3:0]};
   endfunction

   // BCD byte to binary: tens nibble times ten plus ones nibble.
   function automatic logic [6:0] from_bcd(input logic [7:0] b);
      return 7'(7'(b[7:4]) * 7'd10 + 7'(b[3:0]));
   endfunction

endpackage

`default_nettype wire

/* sv/clock_set_and_display_control_core.sv */
// Top level of the clock set and display control block.
//
//   Channel   Direction  Ports                            Contents
//   req       in         req_tvalid/req_tready/req_tdata  clock bytes and switch byte
//   rsp       out        rsp_tvalid/rsp_tready/rsp_tdata  segment codes and write request
//   csr       in         csr_valid/csr_ready/csr_data     settle reload count
//
// A word accepted into the input register passes through the pass logic into the result
// register, from which its result is offered. While rsp does not stall, the pass logic lets
// one word through per cycle, so the block sustains one word per clock. Reset is synchronous
// and active high; it returns all held time state to zero and the settle reload to 250. A
// stall on rsp holds the result register, and the input register then holds one more word
// before req_tready drops.
`default_nettype none

module clock_set_and_display_control_core (
   input  wire                               clock,
   input  wire                               reset,
   // req_tdata, lowest bit first: rtc_seconds_raw[7:0], rtc_minutes_raw[15:8],
   // rtc_hours_raw[23:16], switch_byte[31:24].
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire [csd_pkg::REQ_DATA_W-1:0]     req_tdata,
   // rsp_tdata, lowest bit first: min_ones_segments[7:0], min_tens_segments[15:8],
   // hour_segments[23:16], clock_read_taken[24], write_request[25],
   // write_minutes_bcd[33:26], write_hours_bcd[41:34], zero fill [47:42].
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [csd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // Settle reload register write.
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire [csd_pkg::RELOAD_W-1:0]       csr_data
);

   localparam int unsigned RSP_FIELDS_W = $bits(csd_pkg::csd_rsp_type);

   logic                          in_valid_ff;
   csd_pkg::csd_req_type          in_word_ff;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   csd_pkg::csd_rsp_type          out_word_ff;
   csd_pkg::csd_state_type        state_ff;
   csd_pkg::csd_state_type        state_in;
   csd_pkg::csd_rsp_type          rsp_in;
   logic [csd_pkg::RELOAD_W-1:0]  settle_reload_ff;
   logic                          advance;
   logic                          req_take;

   // The input word moves on whenever the result register is empty or being drained.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   csd_pass u_pass (
      .state_cur     (state_ff),
      .req           (in_word_ff),
      .settle_reload (settle_reload_ff),
      .state_nxt     (state_in),
      .rsp           (rsp_in)
   );

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // Control state and held time.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         out_valid_ff     <= 1'b0;
         state_ff         <= '0;
         settle_reload_ff <= csd_pkg::SETTLE_RELOAD_RESET;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_valid) begin
            settle_reload_ff <= csr_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= csd_pkg::csd_req_type'(req_tdata);
      end
      if (advance) begin
         out_word_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(csd_pkg::RSP_DATA_W - RSP_FIELDS_W)'(0), out_word_ff};

endmodule

`default_nettype wire

/* sv/csd_pass.sv */
// Combinational work of one pass: time load, switch steps, settle count, display and write request.
`default_nettype none

module csd_pass (
   input  wire csd_pkg::csd_state_type        state_cur,
   input  wire csd_pkg::csd_req_type          req,
   input  wire [csd_pkg::RELOAD_W-1:0]        settle_reload,
   output csd_pkg::csd_state_type             state_nxt,
   output csd_pkg::csd_rsp_type               rsp
);

   logic       load;
   logic       hour_pressed;
   logic       minute_pressed;
   logic       hour_step;
   logic       minute_step;
   logic [6:0] sec_loaded;
   logic [6:0] min_loaded;
   logic [4:0] hr_loaded;
   logic [5:0] hr_inc;
   logic [7:0] min_inc;
   logic [csd_pkg::RELOAD_W-1:0] cnt_set;
   logic [7:0] min_bcd;
   logic [7:0] hr_bcd;
   logic [7:0] hour_base;
   logic       do_write;

   always_comb begin
      state_nxt = state_cur;

      // Time load from the clock bytes when idle.
      load       = !state_cur.write_pending && (state_cur.settle_count == '0);
      sec_loaded = csd_pkg::from_bcd({1'b0, req.rtc_seconds_raw[6:0]});
      min_loaded = csd_pkg::from_bcd({1'b0, req.rtc_minutes_raw[6:0]});
      hr_loaded  = 5'(csd_pkg::from_bcd({3'b000, req.rtc_hours_raw[4:0]}));
      if (load) begin
         state_nxt.seconds_value = sec_loaded;
         state_nxt.minutes_value = min_loaded;
         state_nxt.hours_value   = hr_loaded;
      end

      // A step happens when a switch is released.
      hour_pressed   = !req.switch_byte[csd_pkg::HOUR_SW_BIT];
      minute_pressed = !req.switch_byte[csd_pkg::MINUTE_SW_BIT];
      hour_step      = !hour_pressed && state_cur.hour_switch_last;
      minute_step    = !minute_pressed && state_cur.minute_switch_last;

      hr_inc  = {1'b0, state_nxt.hours_value} + 6'd1;
      min_inc = {1'b0, state_nxt.minutes_value} + 8'd1;
      if (hour_step) begin
         state_nxt.hours_value = (hr_inc > csd_pkg::HOUR_MAX) ? 5'd0 : hr_inc[4:0];
      end
      if (minute_step) begin
         state_nxt.minutes_value = (min_inc > csd_pkg::MINUTE_MAX) ? 7'd0 : min_inc[6:0];
      end
      if (hour_step || minute_step) begin
         state_nxt.write_pending = 1'b1;
      end
      state_nxt.hour_switch_last   = hour_pressed;
      state_nxt.minute_switch_last = minute_pressed;

      cnt_set = (hour_step || minute_step) ? settle_reload : state_cur.settle_count;
      state_nxt.settle_count = (cnt_set != '0) ? cnt_set - 1'b1 : cnt_set;

      // Dot toggles on every change of the seconds value.
      if (state_nxt.seconds_value != state_cur.last_seconds_seen) begin
         state_nxt.dot_lit           = !state_cur.dot_lit;
         state_nxt.last_seconds_seen = state_nxt.seconds_value;
      end

      hour_base = (state_nxt.hours_value <= 5'd12)
                ? csd_pkg::hour_code(state_nxt.hours_value[3:0]) : csd_pkg::SEG_BLANK;

      min_bcd = csd_pkg::to_bcd(state_nxt.minutes_value);
      hr_bcd  = csd_pkg::to_bcd({2'b00, state_nxt.hours_value});

      do_write = state_nxt.write_pending && (state_nxt.settle_count == '0);
      if (do_write) begin
         state_nxt.write_pending = 1'b0;
      end

      rsp.min_ones_segments = csd_pkg::digit_code(min_bcd[3:0]);
      rsp.min_tens_segments = csd_pkg::digit_code(min_bcd[7:4]);
      rsp.hour_segments     = state_nxt.dot_lit ? (hour_base & csd_pkg::SEG_DOT_MASK)
                                                : hour_base;
      rsp.clock_read_taken  = load;
      rsp.write_request     = do_write;
      rsp.write_minutes_bcd = do_write ? min_bcd : 8'd0;
      rsp.write_hours_bcd   = do_write ? hr_bcd : 8'd0;
   end

endmodule

`default_nettype wire

/* sv/csd_checker.sv */
// Port-level checker for the clock set and display control block, with its bind.
`default_nettype none

module csd_checker (
   input wire                            clock,
   input wire                            reset,
   input wire                            rsp_tvalid,
   input wire                            rsp_tready,
   input wire [csd_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // A result word that waits keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // Nothing is offered in the cycle after reset.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // The write fields stay zero unless a write is requested.
   a_write_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[25] |-> rsp_tdata[41:26] == 16'd0)
      else $error("write fields set without write request");

   // The fill bits above the fields are zero.
   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[47:42] == 6'd0)
      else $error("fill bits not zero");

   // A requested minute write carries a tens digit of at most eight.
   a_write_minutes: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[25] |-> rsp_tdata[33:30] <= 4'd8)
      else $error("write minutes tens digit out of range");

endmodule

bind clock_set_and_display_control_core csd_checker u_csd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* sim/clock_set_and_display_control_core_tb.sv */
// Self-checking testbench for the clock set and display control core.
`default_nettype none

module clock_set_and_display_control_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Half of the 20 ns clock period.
   localparam time HALF_PERIOD = 10ns;
   // Safety limit on the run. A correct run of about 450 words stays far below it, leaving
   // room for every stall on both sides many times over.
   localparam int unsigned CYCLE_LIMIT = 20_000;
   // Cycles to let pass after the last expected word, well above the block's latency.
   localparam int unsigned DRAIN_CYCLES = 8;
   // Chance in percent that either side idles at each random draw.
   localparam int unsigned IDLE_PERCENT = 17;

   // Mask values for the switch bits of the port expander byte.
   localparam logic [7:0] HOUR_SW_MASK   = 8'h01 << csd_pkg::HOUR_SW_BIT;
   localparam logic [7:0] MINUTE_SW_MASK = 8'h01 << csd_pkg::MINUTE_SW_BIT;
   localparam logic [7:0] BOTH_SW_MASK   = HOUR_SW_MASK | MINUTE_SW_MASK;

   logic                           clock      = 1'b0;
   logic                           reset      = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [csd_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [csd_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           csr_valid  = 1'b0;
   logic                           csr_ready;
   logic [csd_pkg::RELOAD_W-1:0]   csr_data   = '0;

   clock_set_and_display_control_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // The testbench's own copy of the time keeping state. All of it starts at zero.
   typedef struct {
      logic [6:0]  secs;
      logic [6:0]  mins;
      logic [4:0]  hrs;
      logic [6:0]  prev_secs;
      logic        dot_on;
      logic        hr_held;
      logic        min_held;
      logic        write_due;
      logic [15:0] settle_left;
   } clock_time_type;

   clock_time_type               held_time = '{default: '0};
   logic [csd_pkg::RELOAD_W-1:0] settle_reload_copy = csd_pkg::SETTLE_RELOAD_RESET;

   // Result words predicted for the words accepted so far, oldest first.
   csd_pkg::csd_rsp_type predicted_readouts[$];

   int unsigned words_sent   = 0;
   int unsigned words_seen   = 0;
   int unsigned error_count  = 0;
   int unsigned cycle_count  = 0;
   bit          idling_on    = 1'b1;

   // Active-low segment pattern of one decimal digit.
   function automatic logic [7:0] digit_segments(input int d);
      case (d)
         0:       return 8'hC0;
         1:       return 8'hF9;
         2:       return 8'hA4;
         3:       return 8'hB0;
         4:       return 8'h99;
         5:       return 8'h92;
         6:       return 8'h82;
         7:       return 8'hF8;
         8:       return 8'h80;
         default: return 8'h90;
      endcase
   endfunction

   // Hour symbol: the digits, then A for ten, b for eleven and a zero for twelve.
   function automatic logic [7:0] hour_symbol(input int h);
      if (h == 10) return 8'h88;
      if (h == 11) return 8'h83;
      if (h == 12) return digit_segments(0);
      return digit_segments(h);
   endfunction

   // Each nibble is taken as a digit with no range check, so 0x7F reads as 85.
   function automatic int bcd_value(input logic [7:0] b);
      return int'(b[7:4]) * 10 + int'(b[3:0]);
   endfunction

   function automatic logic [7:0] value_bcd(input int v);
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   // One pass of the main loop: load the time, handle the switches and the settle count,
   // build the display codes, then decide on a clock write.
   function automatic csd_pkg::csd_rsp_type advance_clock_pass(input csd_pkg::csd_req_type w);
      csd_pkg::csd_rsp_type r;
      logic                 hr_now;
      logic                 min_now;
      logic [7:0]           base;
      r = '0;
      if (!held_time.write_due && held_time.settle_left == 16'd0) begin
         held_time.secs = 7'(bcd_value(w.rtc_seconds_raw & 8'h7F));
         held_time.mins = 7'(bcd_value(w.rtc_minutes_raw & 8'h7F));
         held_time.hrs  = 5'(bcd_value(w.rtc_hours_raw & 8'h1F));
         r.clock_read_taken = 1'b1;
      end
      // A switch reads as pressed while its bit is low; a step happens on release.
      hr_now  = ~w.switch_byte[csd_pkg::HOUR_SW_BIT];
      min_now = ~w.switch_byte[csd_pkg::MINUTE_SW_BIT];
      if (!hr_now && held_time.hr_held) begin
         held_time.write_due   = 1'b1;
         held_time.settle_left = settle_reload_copy;
         held_time.hrs = (held_time.hrs >= 5'(csd_pkg::HOUR_MAX)) ? 5'd0
                                                                  : held_time.hrs + 5'd1;
      end
      held_time.hr_held = hr_now;
      if (!min_now && held_time.min_held) begin
         held_time.write_due   = 1'b1;
         held_time.settle_left = settle_reload_copy;
         held_time.mins = (held_time.mins >= 7'(csd_pkg::MINUTE_MAX)) ? 7'd0
                                                                      : held_time.mins + 7'd1;
      end
      held_time.min_held = min_now;
      if (held_time.settle_left != 16'd0) held_time.settle_left = held_time.settle_left - 16'd1;
      // The dot flips once for every change of the seconds value.
      if (held_time.secs != held_time.prev_secs) begin
         held_time.dot_on    = ~held_time.dot_on;
         held_time.prev_secs = held_time.secs;
      end
      base = (held_time.hrs <= 5'(csd_pkg::HOUR_MAX)) ? hour_symbol(int'(held_time.hrs))
                                                      : csd_pkg::SEG_BLANK;
      r.hour_segments = held_time.dot_on ? (base & csd_pkg::SEG_DOT_MASK) : base;
      if (held_time.write_due && held_time.settle_left == 16'd0) begin
         r.write_request     = 1'b1;
         r.write_minutes_bcd = value_bcd(int'(held_time.mins));
         r.write_hours_bcd   = value_bcd(int'(held_time.hrs));
         held_time.write_due = 1'b0;
      end
      r.min_ones_segments = digit_segments(int'(held_time.mins) % 10);
      r.min_tens_segments = digit_segments((int'(held_time.mins) / 10) % 10);
      return r;
   endfunction

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string field, input logic [7:0] got,
                                  input logic [7:0] want);
      error_count++;
      $display("ERROR: result word %0d, %s: got %02h, expected %02h", words_seen, field, got,
               want);
   endtask

   // Sends one word, idling first at random, and records its prediction on acceptance.
   task automatic send_pass(input logic [7:0] secs, input logic [7:0] mins,
                            input logic [7:0] hrs, input logic [7:0] sw);
      csd_pkg::csd_req_type w;
      w.rtc_seconds_raw = secs;
      w.rtc_minutes_raw = mins;
      w.rtc_hours_raw   = hrs;
      w.switch_byte     = sw;
      while (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted_readouts.push_back(advance_clock_pass(w));
      words_sent++;
   endtask

   // Stops the sender and waits until every predicted word has come back, then lets the
   // pipeline settle.
   task automatic hold_off();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (predicted_readouts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes the settle reload register. Only called while the block is idle.
   task automatic write_settle_reload(input logic [csd_pkg::RELOAD_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      settle_reload_copy = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // A clock byte that is a well-formed BCD value up to the given limit half of the time
   // and an arbitrary byte otherwise.
   function automatic logic [7:0] random_clock_byte(input int limit);
      if ($urandom_range(1) == 0) return value_bcd($urandom_range(limit));
      return 8'($urandom);
   endfunction

   // The reset value of the reload: one hour step, then the full settle wait before the
   // write goes out and reading resumes.
   task automatic test_reset_reload();
      send_pass(8'h10, 8'h24, 8'h07, 8'hFF);
      send_pass(8'h11, 8'h24, 8'h07, 8'hFF & ~HOUR_SW_MASK);
      send_pass(8'h12, 8'h24, 8'h07, 8'hFF);
      repeat (int'(csd_pkg::SETTLE_RELOAD_RESET) + 5) begin
         send_pass(random_clock_byte(59), random_clock_byte(59), random_clock_byte(12),
                   8'($urandom) | BOTH_SW_MASK);
      end
      hold_off();
   endtask

   // Field extremes and the special cases, with a zero reload so that each step writes
   // in the same pass.
   task automatic test_directed();
      write_settle_reload(16'd0);
      send_pass(8'h00, 8'h00, 8'h00, 8'hFF);
      // Largest legal time: twelve shows as a zero symbol, and the seconds change toggles
      // the dot.
      send_pass(8'h59, 8'h59, 8'h12, 8'hFF);
      // Invalid BCD in every byte: seconds and minutes read as 85, hours as 25, which
      // shows blank with the dot still applied.
      send_pass(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      send_pass(8'h7F, 8'h7F, 8'h13, 8'hFF);
      // Both switches pressed on an hour above twelve, then released: the hour wraps to
      // zero from 25.
      send_pass(8'h00, 8'h00, 8'h1F, 8'h00);
      send_pass(8'h00, 8'h00, 8'h1F, 8'hFF);
      // Hour twelve and minute 59 both wrap to zero on release.
      send_pass(8'h30, 8'h59, 8'h12, 8'hFF & ~HOUR_SW_MASK);
      send_pass(8'h30, 8'h59, 8'h12, 8'hFF & ~BOTH_SW_MASK);
      send_pass(8'h31, 8'h59, 8'h12, 8'hFF);
      // The minute byte loses its top bit and reads as 5, which steps to 6, and the write carries hour 19 as is.
      send_pass(8'h31, 8'h85, 8'h19, 8'hFF & ~MINUTE_SW_MASK);
      send_pass(8'h32, 8'h85, 8'h19, 8'hFF);
      // Hour eleven steps to twelve.
      send_pass(8'h32, 8'h58, 8'h11, 8'hFF & ~HOUR_SW_MASK);
      send_pass(8'h33, 8'h58, 8'h11, 8'hFF);
      // The A and b hour symbols.
      send_pass(8'h45, 8'h07, 8'h10, 8'hFF);
      send_pass(8'h46, 8'h23, 8'h11, 8'hFF);
      // Only the switch bits matter in the expander byte.
      send_pass(8'h00, 8'h00, 8'h09, 8'hCF);
      send_pass(8'h00, 8'h00, 8'h09, BOTH_SW_MASK);
      send_pass(8'h80, 8'h80, 8'hE0, 8'h00);
      send_pass(8'h80, 8'h80, 8'hE0, 8'h00);
      hold_off();
   endtask

   // Largest reload: after one minute step the count starts from the top of its range,
   // and nothing is read or written for the rest of the run.
   task automatic test_long_settle();
      write_settle_reload(16'hFFFF);
      send_pass(8'h05, 8'h42, 8'h03, 8'hFF & ~MINUTE_SW_MASK);
      send_pass(8'h06, 8'h42, 8'h03, 8'hFF);
      repeat (20) begin
         send_pass(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom) | BOTH_SW_MASK);
      end
      hold_off();
   endtask

   // One setting of the reload with random press and release sequences, some noise on
   // the switches, and optionally a pause halfway until everything has come back.
   task automatic random_phase(input int unsigned count,
                               input logic [csd_pkg::RELOAD_W-1:0] reload,
                               input bit pause_halfway);
      int unsigned start;
      int unsigned press_len;
      int unsigned rest_len;
      logic [7:0]  mask;
      bit          paused;
      start  = words_sent;
      paused = 1'b0;
      write_settle_reload(reload);
      while (words_sent - start < count) begin
         if (pause_halfway && !paused && words_sent - start >= count / 2) begin
            hold_off();
            paused = 1'b1;
         end
         if ($urandom_range(99) < 80) begin
            case ($urandom_range(2))
               0:       mask = HOUR_SW_MASK;
               1:       mask = MINUTE_SW_MASK;
               default: mask = BOTH_SW_MASK;
            endcase
            press_len = $urandom_range(1, 3);
            rest_len  = $urandom_range(1, int'(reload) + 3);
            repeat (press_len) begin
               send_pass(random_clock_byte(59), random_clock_byte(59), random_clock_byte(12),
                         (8'($urandom) | BOTH_SW_MASK) & ~mask);
            end
            repeat (rest_len) begin
               send_pass(random_clock_byte(59), random_clock_byte(59), random_clock_byte(12),
                         8'($urandom) | BOTH_SW_MASK);
            end
         end else begin
            send_pass(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
         end
      end
   endtask

   // Several reload settings; the first runs with no idling on either side.
   task automatic test_random();
      hold_off();
      idling_on = 1'b0;
      random_phase(50, 16'd1, 1'b0);
      hold_off();
      idling_on = 1'b1;
      random_phase(20, 16'd2, 1'b0);
      hold_off();
      random_phase(20, 16'd0, 1'b1);
      hold_off();
      random_phase(20, 16'($urandom_range(3, 12)), 1'b0);
      hold_off();
      random_phase(20, 16'd5, 1'b0);
      hold_off();
   endtask

   // Result side: stalls at random and compares every accepted word with the oldest
   // prediction.
   always @(posedge clock) begin : readout_check
      csd_pkg::csd_rsp_type got;
      csd_pkg::csd_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = csd_pkg::csd_rsp_type'(rsp_tdata[$bits(csd_pkg::csd_rsp_type)-1:0]);
            if (predicted_readouts.size() == 0) begin
               report_mismatch("word with nothing expected", got.hour_segments, 8'h00);
            end else begin
               want = predicted_readouts.pop_front();
               if (got.min_ones_segments !== want.min_ones_segments)
                  report_mismatch("min_ones_segments", got.min_ones_segments,
                                  want.min_ones_segments);
               if (got.min_tens_segments !== want.min_tens_segments)
                  report_mismatch("min_tens_segments", got.min_tens_segments,
                                  want.min_tens_segments);
               if (got.hour_segments !== want.hour_segments)
                  report_mismatch("hour_segments", got.hour_segments, want.hour_segments);
               if (got.clock_read_taken !== want.clock_read_taken)
                  report_mismatch("clock_read_taken", 8'(got.clock_read_taken),
                                  8'(want.clock_read_taken));
               if (got.write_request !== want.write_request)
                  report_mismatch("write_request", 8'(got.write_request),
                                  8'(want.write_request));
               if (got.write_minutes_bcd !== want.write_minutes_bcd)
                  report_mismatch("write_minutes_bcd", got.write_minutes_bcd,
                                  want.write_minutes_bcd);
               if (got.write_hours_bcd !== want.write_hours_bcd)
                  report_mismatch("write_hours_bcd", got.write_hours_bcd,
                                  want.write_hours_bcd);
            end
            words_seen++;
         end
         rsp_tready <= !idling_on || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Ends the run with a failure once the cycle count reaches the safety limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ERROR: cycle limit reached with %0d words outstanding",
                  predicted_readouts.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_reload();
      test_directed();
      test_random();
      test_long_settle();
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* clock_set_and_display_control_core.f */
sv/csd_pkg.sv
sv/csd_pass.sv
sv/clock_set_and_display_control_core.sv
sv/csd_checker.sv
sim/clock_set_and_display_control_core_tb.sv
